>>> rtl/core/frt_pkg.sv
// Package: widths, status codes and register indexes of the fragment reassembly tracker.
package frt_pkg;

   localparam int MAX_FRAGS = 512;

   localparam int MAGIC_W  = 16;
   localparam int FNUM_W   = 32;
   localparam int FIDX_W   = 16;
   localparam int PSIZE_W  = 11;
   localparam int OFFS_W   = 20;
   localparam int STATUS_W = 3;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_MAGIC = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_SIZE   = 1'd1;

   localparam logic [MAGIC_W-1:0] MAGIC_RESET = 16'd0;
   localparam logic [PSIZE_W-1:0] PSIZE_RESET = 11'd1400;

   // Bitmap is kept as rows of ROW_W bits in a small memory
   localparam int ROW_W  = 32;
   localparam int BIT_W  = $clog2(ROW_W);
   localparam int ROWS   = (MAX_FRAGS + ROW_W - 1) / ROW_W;
   localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int IDX_W  = ROW_AW + BIT_W;
   localparam int CNT_W  = $clog2(MAX_FRAGS + 1);

   typedef enum logic [STATUS_W-1:0] {
      ST_STORED = 3'd0,
      ST_DUP    = 3'd1,
      ST_MAGIC  = 3'd2,
      ST_ZERO   = 3'd3,
      ST_OTHER  = 3'd4,
      ST_RANGE  = 3'd5,
      ST_MANY   = 3'd6
   } status_type;

endpackage

>>> rtl/core/frt_if.sv
// Interfaces: fragment header request channel and tracking result channel.
interface frt_req_if import frt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [MAGIC_W-1:0] hdr_magic;
   logic [FNUM_W-1:0]  frame_num;
   logic [FIDX_W-1:0]  frag_index;
   logic [FIDX_W-1:0]  frag_count;
   logic               is_end;
   logic [PSIZE_W-1:0] payload_len;

   modport source (output valid, hdr_magic, frame_num, frag_index, frag_count, is_end,
                   payload_len, input ready);
   modport sink   (input valid, hdr_magic, frame_num, frag_index, frag_count, is_end,
                   payload_len, output ready);
endinterface

interface frt_rsp_if import frt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                started_frame;
   logic [OFFS_W-1:0]   write_offset;
   logic [PSIZE_W-1:0]  write_length;
   logic                frame_done;
   logic [OFFS_W-1:0]   frame_bytes;
   logic [FNUM_W-1:0]   done_frame_num;

   modport source (output valid, status, started_frame, write_offset, write_length,
                   frame_done, frame_bytes, done_frame_num, input ready);
   modport sink   (input valid, status, started_frame, write_offset, write_length,
                   frame_done, frame_bytes, done_frame_num, output ready);
endinterface

>>> rtl/core/fragment_reassembly_tracker_unit.sv
// Top level: fragment reassembly tracker, one fragment header checked and tracked per cycle while rsp is not stalled.
//
//   channel | dir | handshake        | carries
//   req     | in  | valid / ready    | one fragment header
//   rsp     | out | valid / ready    | status, write slot, frame completion
//   csr_*   | in  | csr_we           | expected_magic, payload_size
//
// One request per cycle sustained while rsp is not stalled; an accepted request passes
// through the input stage (holding the bitmap row read), then the result register,
// where rsp.valid rises.
// The bitmap row memory has a registered read; a row written by the previous request
// is forwarded, and per-row valid flops clear the whole map without a clearing pass.
// Reset (synchronous) clears control state and row valid flops; no clearing pass.
// A stalled rsp holds the result register; the input stage still takes one more request.
module fragment_reassembly_tracker_unit import frt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   frt_req_if.sink               req,
   frt_rsp_if.source             rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // ---------------- configuration registers ----------------
   logic [MAGIC_W-1:0] magic_ff, magic_in;
   logic [PSIZE_W-1:0] psize_ff, psize_in;

   always_comb begin
      magic_in = magic_ff;
      psize_in = psize_ff;
      if (csr_we && (csr_index == CSR_EXPECTED_MAGIC)) begin
         magic_in = csr_wdata[MAGIC_W-1:0];
      end
      if (csr_we && (csr_index == CSR_PAYLOAD_SIZE)) begin
         psize_in = csr_wdata[PSIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= MAGIC_RESET;
         psize_ff <= PSIZE_RESET;
      end else begin
         magic_ff <= magic_in;
         psize_ff <= psize_in;
      end
   end

   // ---------------- handshake control ----------------
   logic s_valid_ff, s_valid_in;
   logic o_valid_ff, o_valid_in;
   logic accept;
   logic advance;

   // Advance the input stage whenever the result register is free or being drained
   assign advance    = s_valid_ff && (!o_valid_ff || rsp.ready);
   assign req.ready  = !s_valid_ff || advance;
   assign accept     = req.valid && req.ready;

   always_comb begin
      s_valid_in = s_valid_ff;
      if (accept) begin
         s_valid_in = 1'b1;
      end else if (advance) begin
         s_valid_in = 1'b0;
      end
      o_valid_in = o_valid_ff;
      if (advance) begin
         o_valid_in = 1'b1;
      end else if (rsp.ready) begin
         o_valid_in = 1'b0;
      end
   end

   // ---------------- input stage ----------------
   logic [MAGIC_W-1:0] s_magic_ff, s_magic_in;
   logic [FNUM_W-1:0]  s_fnum_ff, s_fnum_in;
   logic [FIDX_W-1:0]  s_idx_ff, s_idx_in;
   logic [FIDX_W-1:0]  s_cnt_ff, s_cnt_in;
   logic               s_end_ff, s_end_in;
   logic [PSIZE_W-1:0] s_len_ff, s_len_in;

   // Hold the captured request while stalled
   always_comb begin
      s_magic_in = accept ? req.hdr_magic   : s_magic_ff;
      s_fnum_in  = accept ? req.frame_num   : s_fnum_ff;
      s_idx_in   = accept ? req.frag_index  : s_idx_ff;
      s_cnt_in   = accept ? req.frag_count  : s_cnt_ff;
      s_end_in   = accept ? req.is_end      : s_end_ff;
      s_len_in   = accept ? req.payload_len : s_len_ff;
   end

   always_ff @(posedge clock) begin
      s_magic_ff <= s_magic_in;
      s_fnum_ff  <= s_fnum_in;
      s_idx_ff   <= s_idx_in;
      s_cnt_ff   <= s_cnt_in;
      s_end_ff   <= s_end_in;
      s_len_ff   <= s_len_in;
   end

   // ---------------- frame state ----------------
   logic [FNUM_W-1:0]  cur_frame_ff, cur_frame_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PSIZE_W-1:0] final_ff, final_in;
   logic [ROWS-1:0]    row_valid_ff, row_valid_in;

   // ---------------- bitmap row memory ----------------
   logic [ROW_W-1:0]  map_mem [ROWS];
   logic [ROW_W-1:0]  rd_ff;
   logic              wr_en;
   logic [ROW_AW-1:0] wr_row;
   logic [ROW_W-1:0]  wr_data;

   // Read the row of the incoming request at acceptance
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= map_mem[req.frag_index[IDX_W-1:BIT_W]];
      end
      if (wr_en) begin
         map_mem[wr_row] <= wr_data;
      end
   end

   // Forward the row written at the edge that loaded the input stage; drop it once
   // the input stage drains
   logic              fwd_ff, fwd_in;
   logic [ROW_AW-1:0] fwd_row_ff, fwd_row_in;
   logic [ROW_W-1:0]  fwd_data_ff, fwd_data_in;

   always_comb begin
      fwd_in      = accept ? wr_en   : (advance ? 1'b0 : fwd_ff);
      fwd_row_in  = accept ? wr_row  : fwd_row_ff;
      fwd_data_in = accept ? wr_data : fwd_data_ff;
   end

   always_ff @(posedge clock) begin
      fwd_row_ff  <= fwd_row_in;
      fwd_data_ff <= fwd_data_in;
   end

   // ---------------- checks and tracking ----------------
   logic                     bad_magic, zero_total, too_many, ok;
   logic                     start;
   logic [FNUM_W-1:0]        frame_eff;
   logic [CNT_W-1:0]         total_eff;
   logic [CNT_W-1:0]         count_base;
   logic [PSIZE_W-1:0]       final_base;
   logic                     other, out_range, in_frame;
   logic [IDX_W-1:0]         idx;
   logic [ROW_AW-1:0]        row;
   logic [BIT_W-1:0]         bitpos;
   logic [ROW_W-1:0]         row_base, row_data;
   logic                     seen, store, done;
   logic [PSIZE_W-1:0]       wlen;
   logic [IDX_W+PSIZE_W-1:0] woff_prod;
   logic [CNT_W-1:0]         total_m1;
   logic [CNT_W+PSIZE_W-1:0] fb_prod;
   logic [CNT_W-1:0]         count_new;
   logic [PSIZE_W-1:0]       final_new;
   logic [OFFS_W-1:0]        fbytes;
   status_type               status;

   always_comb begin
      bad_magic  = s_magic_ff != magic_ff;
      zero_total = s_cnt_ff == '0;
      too_many   = s_cnt_ff > FIDX_W'(MAX_FRAGS);
      ok         = !bad_magic && !zero_total && !too_many;

      // Fragment 0 of a different frame opens a new frame
      start      = ok && (s_idx_ff == '0) && (s_fnum_ff != cur_frame_ff);
      frame_eff  = start ? s_fnum_ff : cur_frame_ff;
      total_eff  = start ? s_cnt_ff[CNT_W-1:0] : total_ff;
      count_base = start ? '0 : count_ff;
      final_base = start ? '0 : final_ff;

      other      = s_fnum_ff != frame_eff;
      out_range  = (s_idx_ff >= FIDX_W'(total_eff)) || (s_idx_ff >= FIDX_W'(MAX_FRAGS));
      in_frame   = ok && !other && !out_range;

      idx        = s_idx_ff[IDX_W-1:0];
      row        = idx[IDX_W-1:BIT_W];
      bitpos     = idx[BIT_W-1:0];

      row_base   = (fwd_ff && (fwd_row_ff == row)) ? fwd_data_ff : rd_ff;
      row_data   = (start || !row_valid_ff[row]) ? '0 : row_base;
      seen       = row_data[bitpos];
      store      = in_frame && !seen;

      wlen       = (s_len_ff < psize_ff) ? s_len_ff : psize_ff;
      woff_prod  = (IDX_W+PSIZE_W)'(idx) * (IDX_W+PSIZE_W)'(psize_ff);

      count_new  = count_base + CNT_W'(store);
      final_new  = (store && s_end_ff) ? wlen : final_base;
      done       = in_frame && (count_new == total_eff);

      total_m1   = total_eff - CNT_W'(1);
      fb_prod    = (CNT_W+PSIZE_W)'(total_m1) * (CNT_W+PSIZE_W)'(psize_ff);
      fbytes     = OFFS_W'(fb_prod) + OFFS_W'(final_new);

      if (bad_magic) begin
         status = ST_MAGIC;
      end else if (zero_total) begin
         status = ST_ZERO;
      end else if (too_many) begin
         status = ST_MANY;
      end else if (other) begin
         status = ST_OTHER;
      end else if (out_range) begin
         status = ST_RANGE;
      end else if (seen) begin
         status = ST_DUP;
      end else begin
         status = ST_STORED;
      end

      wr_en   = advance && store && !done;
      wr_row  = row;
      wr_data = row_data | (ROW_W'(1) << bitpos);
   end

   // Update the frame state as the request leaves the input stage
   always_comb begin
      cur_frame_in = cur_frame_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      final_in     = final_ff;
      row_valid_in = row_valid_ff;
      if (advance) begin
         if (done) begin
            cur_frame_in = '0;
            total_in     = '0;
            count_in     = '0;
            final_in     = '0;
            row_valid_in = '0;
         end else if (in_frame) begin
            cur_frame_in = frame_eff;
            total_in     = total_eff;
            count_in     = count_new;
            final_in     = final_new;
            if (start) begin
               row_valid_in = '0;
            end
            if (store) begin
               row_valid_in[row] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff   <= 1'b0;
         o_valid_ff   <= 1'b0;
         fwd_ff       <= 1'b0;
         cur_frame_ff <= '0;
         total_ff     <= '0;
         count_ff     <= '0;
         final_ff     <= '0;
         row_valid_ff <= '0;
      end else begin
         s_valid_ff   <= s_valid_in;
         o_valid_ff   <= o_valid_in;
         fwd_ff       <= fwd_in;
         cur_frame_ff <= cur_frame_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         final_ff     <= final_in;
         row_valid_ff <= row_valid_in;
      end
   end

   // ---------------- result register ----------------
   logic [STATUS_W-1:0] o_status_ff, o_status_in;
   logic                o_started_ff, o_started_in;
   logic [OFFS_W-1:0]   o_woff_ff, o_woff_in;
   logic [PSIZE_W-1:0]  o_wlen_ff, o_wlen_in;
   logic                o_done_ff, o_done_in;
   logic [OFFS_W-1:0]   o_fbytes_ff, o_fbytes_in;
   logic [FNUM_W-1:0]   o_dnum_ff, o_dnum_in;

   always_comb begin
      o_status_in  = o_status_ff;
      o_started_in = o_started_ff;
      o_woff_in    = o_woff_ff;
      o_wlen_in    = o_wlen_ff;
      o_done_in    = o_done_ff;
      o_fbytes_in  = o_fbytes_ff;
      o_dnum_in    = o_dnum_ff;
      if (advance) begin
         o_status_in  = status;
         o_started_in = start;
         o_woff_in    = store ? OFFS_W'(woff_prod) : '0;
         o_wlen_in    = store ? wlen : '0;
         o_done_in    = done;
         o_fbytes_in  = done ? fbytes : '0;
         o_dnum_in    = done ? frame_eff : '0;
      end
   end

   always_ff @(posedge clock) begin
      o_status_ff  <= o_status_in;
      o_started_ff <= o_started_in;
      o_woff_ff    <= o_woff_in;
      o_wlen_ff    <= o_wlen_in;
      o_done_ff    <= o_done_in;
      o_fbytes_ff  <= o_fbytes_in;
      o_dnum_ff    <= o_dnum_in;
   end

   assign rsp.valid          = o_valid_ff;
   assign rsp.status         = o_status_ff;
   assign rsp.started_frame  = o_started_ff;
   assign rsp.write_offset   = o_woff_ff;
   assign rsp.write_length   = o_wlen_ff;
   assign rsp.frame_done     = o_done_ff;
   assign rsp.frame_bytes    = o_fbytes_ff;
   assign rsp.done_frame_num = o_dnum_ff;

   // ---------------- assertions ----------------
   // A completed frame comes only from a request of that frame
   a_done_status: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.frame_done |-> (rsp.status == ST_STORED || rsp.status == ST_DUP))
      else $error("frame_done with a dropped status");

   // Completion returns the tracker to the idle frame
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      advance && done |=> (cur_frame_ff == '0) && (count_ff == '0) && (row_valid_ff == '0))
      else $error("frame state not cleared after completion");

   // Received count never passes the frame total
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= total_ff)
      else $error("received count above expected total");

   // Only a stored fragment carries a write slot
   a_slot_only_stored: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.status != ST_STORED) |-> (rsp.write_offset == '0)
                                                 && (rsp.write_length == '0))
      else $error("write slot on a fragment that was not stored");

   // A forwarded row is only ever live while a request sits in the input stage
   a_fwd_live: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> s_valid_ff)
      else $error("row forward armed with an empty input stage");

endmodule
